@@ rtl/block_bitmap_allocator_top_macros.svh @@
// Assertion macros of the block bitmap allocator RTL, included by the sequencer.
// Used by modules that have clk and arst_n in scope; no other dependencies.
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BBA_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BBA_ASSERT(label, prop, msg)
`define BBA_ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ rtl/bba_pkg.sv @@
// Types, field widths and codes for the block bitmap allocator.
// No dependencies; the RTL files other than the bitmap memory and the macro header refer to it by scoped names.
`default_nettype none
package bba_pkg;
	localparam int unsigned BLOCK_W  = 24;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned FREE_W   = 17;
	localparam int unsigned MAPS_W   = 4;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned FREE_MAX = 131071;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_MAP   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ALR_FREE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	localparam logic [1:0] REG_FIRST = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;
	localparam logic [1:0] REG_MAPS  = 2'd2;

	localparam logic [BLOCK_W-1:0] FIRST_RST = 24'd1;
	localparam logic [BLOCK_W-1:0] LIMIT_RST = 24'd65536;
	localparam logic [MAPS_W-1:0]  MAPS_RST  = 4'd8;

	typedef struct packed {
		logic [BLOCK_W-1:0] first_data_block;
		logic [BLOCK_W-1:0] block_limit;
		logic [MAPS_W-1:0]  maps_in_use;
	} cfg_t;
endpackage
`default_nettype wire

@@ rtl/bba_ifs.sv @@
// Request and response channel interfaces of the block bitmap allocator.
// Depends on bba_pkg for the field widths.
`default_nettype none
interface bba_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [bba_pkg::BLOCK_W-1:0]   block_number;
	modport source (output valid, output req_type, output block_number, input ready);
	modport sink (input valid, input req_type, input block_number, output ready);
endinterface

interface bba_resp_if;
	logic                          valid;
	logic                          ready;
	logic [bba_pkg::BLOCK_W-1:0]   allocated_block;
	logic [bba_pkg::STATUS_W-1:0]  status;
	logic [bba_pkg::FREE_W-1:0]    free_count;
	modport source (output valid, output allocated_block, output status,
		output free_count, input ready);
	modport sink (input valid, input allocated_block, input status,
		input free_count, output ready);
endinterface
`default_nettype wire

@@ rtl/bba_cfg_regs.sv @@
// APB-style configuration registers of the block bitmap allocator.
// Depends on bba_pkg for the register codes, reset values and cfg_t.
`default_nettype none
module bba_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bba_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bba_pkg::DATA_W-1:0]   pwdata,
	output logic      [bba_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output bba_pkg::cfg_t                     cfg
);
	bba_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_data_block <= bba_pkg::FIRST_RST;
			cfg_q.block_limit      <= bba_pkg::LIMIT_RST;
			cfg_q.maps_in_use      <= bba_pkg::MAPS_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				bba_pkg::REG_FIRST: cfg_q.first_data_block <= pwdata[bba_pkg::BLOCK_W-1:0];
				bba_pkg::REG_LIMIT: cfg_q.block_limit      <= pwdata[bba_pkg::BLOCK_W-1:0];
				bba_pkg::REG_MAPS:  cfg_q.maps_in_use      <= pwdata[bba_pkg::MAPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bba_pkg::REG_FIRST: prdata = 32'(cfg_q.first_data_block);
			bba_pkg::REG_LIMIT: prdata = 32'(cfg_q.block_limit);
			bba_pkg::REG_MAPS:  prdata = 32'(cfg_q.maps_in_use);
			default:            prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/bba_bitmap_mem.sv @@
// Single-port-write, single-port-read word memory holding the usage bitmap.
// No dependencies; read data is registered.
`default_nettype none
module bba_bitmap_mem #(
	parameter int unsigned WORD_BITS  = 64,
	parameter int unsigned WORD_COUNT = 1024,
	localparam int unsigned AW        = $clog2(WORD_COUNT)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WORD_BITS-1:0] wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WORD_BITS-1:0] rdata
);
	logic [WORD_BITS-1:0] mem [WORD_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/bba_seq.sv @@
// Sequencer of the block bitmap allocator: free check, word scan, bit search,
// per-map counters and free count. Depends on bba_pkg, the channel
// interfaces and the assertion macro header.
`default_nettype none
`include "block_bitmap_allocator_top_macros.svh"
module bba_seq #(
	parameter int unsigned BITS_PER_MAP = 8192,
	parameter int unsigned MAX_MAPS     = 8,
	parameter int unsigned WORD_BITS    = 64,
	localparam int unsigned WORD_COUNT  = (MAX_MAPS * BITS_PER_MAP) / WORD_BITS,
	localparam int unsigned AW          = $clog2(WORD_COUNT)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	bba_req_if.sink                   req,
	bba_resp_if.source                resp,
	input  wire bba_pkg::cfg_t        cfg,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [WORD_BITS-1:0]      mem_wdata,
	output logic                      mem_re,
	output logic [AW-1:0]             mem_raddr,
	input  wire logic [WORD_BITS-1:0] mem_rdata
);
	localparam int unsigned TOTAL   = MAX_MAPS * BITS_PER_MAP;
	localparam int unsigned LOG_WB  = $clog2(WORD_BITS);
	localparam int unsigned LOG_BPM = $clog2(BITS_PER_MAP);
	localparam int unsigned LOG_WPM = $clog2(BITS_PER_MAP / WORD_BITS);
	localparam int unsigned GW      = AW + LOG_WB;
	localparam int unsigned CW      = $clog2(WORD_COUNT + 1);
	localparam int unsigned TBW     = $clog2(TOTAL + 1);
	localparam int unsigned UW      = $clog2(BITS_PER_MAP + 1);
	localparam int unsigned AMW     = $clog2(MAX_MAPS + 1);
	localparam int unsigned MW      = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
	localparam int unsigned XW      = bba_pkg::BLOCK_W + 1;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_FCHK  = 4'd2;
	localparam logic [3:0] S_FSUB  = 4'd3;
	localparam logic [3:0] S_FMAP  = 4'd4;
	localparam logic [3:0] S_FWAIT = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_BITS  = 4'd7;
	localparam logic [3:0] S_AWR   = 4'd8;
	localparam logic [3:0] S_ACHK  = 4'd9;
	localparam logic [3:0] S_SUM   = 4'd10;
	localparam logic [3:0] S_RESP  = 4'd11;

	logic [3:0]                   state_q;
	logic [AW-1:0]                clr_idx_q;
	logic                         req_type_q;
	logic [bba_pkg::BLOCK_W-1:0]  blk_q;
	logic [XW-1:0]                g_q;
	logic [XW-1:0]                j_q;
	logic [CW-1:0]                issue_q;
	logic                         rvalid_q;
	logic [AW-1:0]                ridx_q;
	logic [AW-1:0]                widx_q;
	logic [WORD_BITS-1:0]         orig_q;
	logic [WORD_BITS-1:0]         word_q;
	logic [LOG_WB-1:0]            bcnt_q;
	logic [UW-1:0]                map_used_q [MAX_MAPS];
	logic [AMW-1:0]               sum_idx_q;
	logic [TBW-1:0]               sum_q;
	logic [bba_pkg::BLOCK_W-1:0]  res_block_q;
	logic [bba_pkg::STATUS_W-1:0] status_q;
	logic                         out_valid_q;
	logic [bba_pkg::BLOCK_W-1:0]  out_block_q;
	logic [bba_pkg::STATUS_W-1:0] out_status_q;
	logic [bba_pkg::FREE_W-1:0]   out_free_q;

	logic [AMW-1:0]       act;
	logic [CW-1:0]        wlim;
	logic [TBW-1:0]       total_bits;
	logic [TBW-1:0]       free_w;
	logic [GW-1:0]        found_bit;
	logic [MW-1:0]        map_free;
	logic [MW-1:0]        map_alloc;
	logic [MW-1:0]        mu_idx;
	logic [UW-1:0]        mu_rd;
	logic                 map_ok;
	logic                 free_bit;
	logic                 scan_hit;
	logic                 scan_issue;
	logic                 accept;
	logic                 out_free;

	// Maps beyond the built capacity count as the capacity.
	assign act = ({1'b0, cfg.maps_in_use} > 5'(MAX_MAPS)) ? AMW'(MAX_MAPS)
		: AMW'(cfg.maps_in_use);
	assign wlim       = CW'(32'(act) << LOG_WPM);
	assign total_bits = TBW'(32'(act) << LOG_BPM);
	assign free_w     = total_bits - sum_q;

	assign found_bit = {widx_q, bcnt_q};
	assign map_free  = XW'(g_q >> LOG_BPM) == '0 ? '0 : MW'(g_q >> LOG_BPM);
	assign map_alloc = MW'(found_bit >> LOG_BPM);
	assign map_ok    = (g_q >> LOG_BPM) < XW'(act);
	assign free_bit  = mem_rdata[g_q[LOG_WB-1:0]];

	assign scan_hit   = rvalid_q && !(&mem_rdata);
	assign scan_issue = !scan_hit && (issue_q < wlim);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || resp.ready;

	assign resp.valid           = out_valid_q;
	assign resp.allocated_block = out_block_q;
	assign resp.status          = out_status_q;
	assign resp.free_count      = out_free_q;

	always_comb begin
		priority if (state_q == S_SUM) begin
			mu_idx = MW'(sum_idx_q);
		end else if (state_q == S_FWAIT) begin
			mu_idx = map_free;
		end else begin
			mu_idx = map_alloc;
		end
	end
	assign mu_rd = map_used_q[mu_idx];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_idx_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = issue_q[AW-1:0];
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
			end
			S_FMAP: begin
				mem_re    = map_ok;
				mem_raddr = g_q[GW-1:LOG_WB];
			end
			S_FWAIT: begin
				mem_we    = free_bit;
				mem_waddr = g_q[GW-1:LOG_WB];
				mem_wdata = mem_rdata & ~(WORD_BITS'(1) << g_q[LOG_WB-1:0]);
			end
			S_SCAN: begin
				mem_re = scan_issue;
			end
			S_AWR: begin
				mem_we    = 1'b1;
				mem_waddr = widx_q;
				mem_wdata = orig_q | (WORD_BITS'(1) << bcnt_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_idx_q   <= '0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
			issue_q     <= '0;
			sum_idx_q   <= '0;
			for (int i = 0; i < MAX_MAPS; i++) begin
				map_used_q[i] <= '0;
			end
		end else begin
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == AW'(WORD_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						req_type_q  <= req.req_type;
						blk_q       <= req.block_number;
						res_block_q <= '0;
						status_q    <= bba_pkg::ST_OK;
						sum_q       <= '0;
						sum_idx_q   <= '0;
						issue_q     <= '0;
						rvalid_q    <= 1'b0;
						state_q     <= (req.req_type == bba_pkg::REQ_FREE) ? S_FCHK : S_SCAN;
					end
				end
				S_FCHK: begin
					if (blk_q < cfg.first_data_block || blk_q >= cfg.block_limit) begin
						status_q <= bba_pkg::ST_RANGE;
						state_q  <= S_SUM;
					end else begin
						state_q <= S_FSUB;
					end
				end
				S_FSUB: begin
					g_q     <= XW'(blk_q) - XW'(cfg.first_data_block) + XW'(1);
					state_q <= S_FMAP;
				end
				S_FMAP: begin
					if (map_ok) begin
						state_q <= S_FWAIT;
					end else begin
						status_q <= bba_pkg::ST_NO_MAP;
						state_q  <= S_SUM;
					end
				end
				S_FWAIT: begin
					if (free_bit) begin
						map_used_q[mu_idx] <= mu_rd - UW'(1);
					end else begin
						status_q <= bba_pkg::ST_ALR_FREE;
					end
					state_q <= S_SUM;
				end
				S_SCAN: begin
					// Reads are issued back to back; each word is checked in the cycle after its read is issued.
					if (scan_hit) begin
						orig_q   <= mem_rdata;
						word_q   <= mem_rdata;
						widx_q   <= ridx_q;
						bcnt_q   <= '0;
						rvalid_q <= 1'b0;
						state_q  <= S_BITS;
					end else if (scan_issue) begin
						ridx_q   <= issue_q[AW-1:0];
						issue_q  <= issue_q + CW'(1);
						rvalid_q <= 1'b1;
					end else begin
						rvalid_q <= 1'b0;
						status_q <= bba_pkg::ST_FULL;
						state_q  <= S_SUM;
					end
				end
				S_BITS: begin
					if (!word_q[0]) begin
						state_q <= S_AWR;
					end else begin
						word_q <= word_q >> 1;
						bcnt_q <= bcnt_q + LOG_WB'(1);
					end
				end
				S_AWR: begin
					map_used_q[mu_idx] <= mu_rd + UW'(1);
					j_q     <= XW'(found_bit) + XW'(cfg.first_data_block) - XW'(1);
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					// Bit zero of the first map lies one below the first data block.
					if (found_bit == '0 || j_q >= XW'(cfg.block_limit)) begin
						status_q <= bba_pkg::ST_RANGE;
					end else begin
						res_block_q <= j_q[bba_pkg::BLOCK_W-1:0];
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (sum_idx_q < act) begin
						sum_q     <= sum_q + TBW'(mu_rd);
						sum_idx_q <= sum_idx_q + AMW'(1);
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_block_q  <= res_block_q;
						out_status_q <= status_q;
						out_free_q   <= (32'(free_w) > bba_pkg::FREE_MAX)
							? bba_pkg::FREE_W'(bba_pkg::FREE_MAX) : bba_pkg::FREE_W'(free_w);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BBA_ASSERT(a_bits_word_has_zero, (state_q == S_BITS) |-> !(&word_q), "bit search on a full word")
	`BBA_ASSERT(a_sum_within_total, (state_q == S_RESP) |-> (sum_q <= total_bits), "used count above map bits")
	`BBA_ASSERT_NEVER(a_full_with_block, resp.valid && resp.status == bba_pkg::ST_FULL && resp.allocated_block != '0, "full response carries a block")
	`BBA_ASSERT_NEVER(a_alloc_on_free_path, (state_q == S_AWR) && (req_type_q == bba_pkg::REQ_FREE), "allocate write during a free")
endmodule
`default_nettype wire

@@ rtl/block_bitmap_allocator_top.sv @@
// Block bitmap allocator, one item at a time. A free checks the range and the map, reads the
// word and clears the bit if set, stopping at a failed check; an allocate reads words through
// the single bitmap port until one has a clear bit, finds that bit in its word, sets it and
// checks the range. Both then sum the maps in use, one counter a cycle. The next item can be
// taken in the same cycle as the response is presented. After reset the bitmap is cleared one
// word a cycle (1024 words by default); requests wait for that pass, register writes do not.
`default_nettype none
module block_bitmap_allocator_top #(
	parameter int unsigned BITS_PER_MAP = 8192,
	parameter int unsigned MAX_MAPS     = 8,
	parameter int unsigned WORD_BITS    = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bba_req_if.sink                          req,
	bba_resp_if.source                       resp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bba_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [bba_pkg::DATA_W-1:0]  pwdata,
	output logic      [bba_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);
	localparam int unsigned WORD_COUNT = (MAX_MAPS * BITS_PER_MAP) / WORD_BITS;
	localparam int unsigned AW         = $clog2(WORD_COUNT);

	bba_pkg::cfg_t        cfg;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	bba_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bba_bitmap_mem #(
		.WORD_BITS  (WORD_BITS),
		.WORD_COUNT (WORD_COUNT)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bba_seq #(
		.BITS_PER_MAP (BITS_PER_MAP),
		.MAX_MAPS     (MAX_MAPS),
		.WORD_BITS    (WORD_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.resp      (resp),
		.cfg       (cfg),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);
endmodule
`default_nettype wire

@@ sim/tb_block_bitmap_allocator_top.sv @@
// Self-checking testbench for block_bitmap_allocator_top: request and response channels,
// APB register writes, and a scoreboard that predicts every response item.
// Depends on bba_pkg, the channel interfaces in bba_ifs.sv and the allocator RTL.
`default_nettype none
module tb_block_bitmap_allocator_top;
	localparam int unsigned BITS_PER_MAP = 8192;
	localparam int unsigned MAX_MAPS     = 8;
	localparam int unsigned TOTAL_BITS   = BITS_PER_MAP * MAX_MAPS;
	localparam int unsigned IDLE_LIMIT   = 20000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned TAIL_CYCLES  = 1200;
	localparam int unsigned RANDOM_ITEMS = 580;
	localparam int unsigned PHASES       = 8;

	typedef struct packed {
		logic [bba_pkg::BLOCK_W-1:0]  blk;
		logic [bba_pkg::STATUS_W-1:0] st;
		logic [bba_pkg::FREE_W-1:0]   free;
	} alloc_result_t;

	class alloc_scoreboard;
		bit                          used_bit [TOTAL_BITS];
		int unsigned                 map_fill [MAX_MAPS];
		logic [bba_pkg::BLOCK_W-1:0] first_blk;
		logic [bba_pkg::BLOCK_W-1:0] blk_limit;
		logic [bba_pkg::MAPS_W-1:0]  map_reg;
		alloc_result_t               expected_q [$];
		int                          errors;
		int                          top_bit;

		function new();
			first_blk = bba_pkg::FIRST_RST;
			blk_limit = bba_pkg::LIMIT_RST;
			map_reg   = bba_pkg::MAPS_RST;
			errors    = 0;
			top_bit   = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [bba_pkg::DATA_W-1:0] val);
			case (idx)
				bba_pkg::REG_FIRST: first_blk = val[bba_pkg::BLOCK_W-1:0];
				bba_pkg::REG_LIMIT: blk_limit = val[bba_pkg::BLOCK_W-1:0];
				bba_pkg::REG_MAPS:  map_reg = val[bba_pkg::MAPS_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned maps_active();
			return (map_reg > MAX_MAPS) ? MAX_MAPS : int'(map_reg);
		endfunction

		// Only the maps in use are counted; bits left in the others stay put.
		function logic [bba_pkg::FREE_W-1:0] free_blocks();
			int unsigned maps;
			int unsigned sum;
			int unsigned total;
			maps = maps_active();
			sum = 0;
			for (int unsigned i = 0; i < maps; i++)
				sum += map_fill[i];
			total = maps * BITS_PER_MAP - sum;
			if (total > bba_pkg::FREE_MAX)
				total = bba_pkg::FREE_MAX;
			return total[bba_pkg::FREE_W-1:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Picks a set bit at random, so that most frees hit a block in use.
		function int pick_used();
			int g;
			if (top_bit == 0)
				return -1;
			for (int t = 0; t < 8; t++) begin
				g = $urandom_range(1, top_bit);
				if (used_bit[g])
					return g;
			end
			return -1;
		endfunction

		function void note_request(logic rt, logic [bba_pkg::BLOCK_W-1:0] bn);
			alloc_result_t r;
			int unsigned maps;
			int unsigned lim;
			int unsigned g;
			int unsigned m;
			int unsigned found;
			longint j;
			bit hit;
			maps  = maps_active();
			r.blk = '0;
			r.st  = bba_pkg::ST_OK;
			found = 0;
			hit   = 0;
			if (rt == bba_pkg::REQ_FREE) begin
				if (bn < first_blk || bn >= blk_limit) begin
					r.st = bba_pkg::ST_RANGE;
				end else begin
					g = 32'(bn) - 32'(first_blk) + 1;
					m = g / BITS_PER_MAP;
					if (m >= maps) begin
						r.st = bba_pkg::ST_NO_MAP;
					end else if (!used_bit[g]) begin
						r.st = bba_pkg::ST_ALR_FREE;
					end else begin
						used_bit[g] = 0;
						map_fill[m]--;
					end
				end
			end else begin
				lim = maps * BITS_PER_MAP;
				for (int unsigned k = 0; k < lim; k++) begin
					if (!used_bit[k]) begin
						found = k;
						hit = 1;
						break;
					end
				end
				if (!hit) begin
					r.st = bba_pkg::ST_FULL;
				end else begin
					used_bit[found] = 1;
					map_fill[found / BITS_PER_MAP]++;
					if (int'(found) > top_bit)
						top_bit = found;
					// The bit stays set even when the block it stands for is out of range.
					j = longint'(found) + longint'(first_blk) - 1;
					if (j < longint'(first_blk) || j >= longint'(blk_limit))
						r.st = bba_pkg::ST_RANGE;
					else
						r.blk = j[bba_pkg::BLOCK_W-1:0];
				end
			end
			r.free = free_blocks();
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(logic [bba_pkg::BLOCK_W-1:0] blk, logic [bba_pkg::STATUS_W-1:0] st,
				logic [bba_pkg::FREE_W-1:0] fc);
			alloc_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("response with nothing pending: block %0d status %0d free %0d",
					blk, st, fc));
				return;
			end
			e = expected_q.pop_front();
			if (blk !== e.blk)
				report($sformatf("allocated_block %0d, predicted %0d", blk, e.blk));
			if (st !== e.st)
				report($sformatf("status %0d, predicted %0d", st, e.st));
			if (fc !== e.free)
				report($sformatf("free_count %0d, predicted %0d", fc, e.free));
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [bba_pkg::ADDR_W-1:0]  paddr;
	logic [bba_pkg::DATA_W-1:0]  pwdata;
	logic [bba_pkg::DATA_W-1:0]  prdata;
	logic                        pready;
	bit                          quiet = 0;
	bit                          hold_request = 0;
	int unsigned                 idle_cycles = 0;
	alloc_scoreboard             sb = new();

	bba_req_if  req_ch();
	bba_resp_if resp_ch();

	block_bitmap_allocator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.resp    (resp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// Every task below is entered and left on a falling edge.
	task send_request(logic rt, logic [bba_pkg::BLOCK_W-1:0] bn);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= rt;
		req_ch.block_number <= bn;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(rt, bn);
		@(negedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [bba_pkg::DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Registers change only once every pending response has come back.
	task apply_cfg(logic [bba_pkg::BLOCK_W-1:0] first, logic [bba_pkg::BLOCK_W-1:0] limit,
			logic [bba_pkg::MAPS_W-1:0] maps);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		write_reg(bba_pkg::REG_FIRST, {8'($urandom), first});
		write_reg(bba_pkg::REG_LIMIT, {8'($urandom), limit});
		write_reg(bba_pkg::REG_MAPS, {28'($urandom), maps});
	endtask

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("block_bitmap_allocator_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		int burst;
		int hold_left;
		burst = 0;
		hold_left = 0;
		resp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				resp_ch.ready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				resp_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 5) - 1;
				resp_ch.ready <= 1'b0;
			end else begin
				resp_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1)
				sb.check_result(resp_ch.allocated_block, resp_ch.status, resp_ch.free_count);
		end
	end

	initial begin
		logic [bba_pkg::BLOCK_W-1:0] f;
		logic [bba_pkg::BLOCK_W-1:0] l;
		logic [bba_pkg::MAPS_W-1:0]  m;
		logic [bba_pkg::BLOCK_W-1:0] bn;
		int                          g;
		int                          sel;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = bba_pkg::REQ_ALLOC;
		req_ch.block_number = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings. The first allocation lands on bit 0, one block below the first.
		send_request(bba_pkg::REQ_ALLOC, 24'hFFFFFF);
		send_request(bba_pkg::REQ_ALLOC, 24'h000000);
		send_request(bba_pkg::REQ_ALLOC, 24'h000000);
		send_request(bba_pkg::REQ_ALLOC, 24'h000000);
		send_request(bba_pkg::REQ_FREE, 24'd2);
		send_request(bba_pkg::REQ_FREE, 24'd2);
		send_request(bba_pkg::REQ_FREE, 24'd0);
		send_request(bba_pkg::REQ_FREE, 24'd65536);
		send_request(bba_pkg::REQ_FREE, 24'hFFFFFF);
		send_request(bba_pkg::REQ_FREE, 24'd65535);
		send_request(bba_pkg::REQ_ALLOC, 24'h000000);

		// Highest first block and limit, maps register above the number of maps.
		apply_cfg(24'hFFFFFF, 24'hFFFFFF, 4'd15);
		send_request(bba_pkg::REQ_ALLOC, 24'h000000);
		send_request(bba_pkg::REQ_FREE, 24'hFFFFFF);
		send_request(bba_pkg::REQ_FREE, 24'hFFFFFE);

		// A single map: frees beyond it have no map to go to.
		apply_cfg(24'd100, 24'hFFFFFF, 4'd1);
		send_request(bba_pkg::REQ_ALLOC, 24'h000000);
		send_request(bba_pkg::REQ_FREE, 24'(100 + BITS_PER_MAP - 1));
		send_request(bba_pkg::REQ_FREE, 24'hFFFFFE);
		send_request(bba_pkg::REQ_FREE, 24'd104);

		// No maps in use at all.
		apply_cfg(24'd1, 24'hFFFFFF, 4'd0);
		send_request(bba_pkg::REQ_ALLOC, 24'h000000);
		send_request(bba_pkg::REQ_FREE, 24'd3);

		// Lowest limit: every block handed out is out of range.
		apply_cfg(24'd1, 24'd1, 4'd8);
		send_request(bba_pkg::REQ_ALLOC, 24'h000000);
		send_request(bba_pkg::REQ_FREE, 24'd0);

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				quiet = 1;
				apply_cfg(24'd1, 24'd65536, 4'd8);
			end else begin
				case ($urandom_range(0, 4))
					0: f = 24'd1;
					1, 2: f = 24'($urandom_range(2, 300));
					3: f = 24'($urandom_range(16776900, 16777215));
					default: f = 24'($urandom_range(1, 16777215));
				endcase
				case ($urandom_range(0, 4))
					0: l = 24'd65536;
					1: l = (f > 24'hFFFE00) ? 24'hFFFFFF : f + 24'($urandom_range(1, 400));
					2: l = 24'hFFFFFF;
					3: l = 24'd1;
					default: l = 24'($urandom_range(1, 16777215));
				endcase
				case ($urandom_range(0, 7))
					0: m = 4'd0;
					1: m = 4'($urandom_range(9, 15));
					default: m = 4'($urandom_range(1, 8));
				endcase
				apply_cfg(f, l, m);
			end
			for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
				// The response side stops for a long while so that the block backs up.
				if (p == 1 && k == 10)
					hold_request = 1;
				sel = $urandom_range(0, 99);
				if (sel < 55) begin
					send_request(bba_pkg::REQ_ALLOC, 24'($urandom));
				end else if (sel < 88) begin
					g = sb.pick_used();
					if (g < 0)
						send_request(bba_pkg::REQ_ALLOC, 24'($urandom));
					else
						send_request(bba_pkg::REQ_FREE, 24'(g + int'(sb.first_blk) - 1));
				end else begin
					case ($urandom_range(0, 4))
						0: bn = 24'($urandom);
						1: bn = sb.first_blk - 24'd1;
						2: bn = sb.blk_limit;
						3: bn = sb.blk_limit - 24'd1;
						default: bn = 24'(int'(sb.first_blk) + BITS_PER_MAP * sb.map_reg - 1);
					endcase
					send_request(bba_pkg::REQ_FREE, bn);
				end
			end
		end

		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("block_bitmap_allocator_top verification clean");
		else
			$display("block_bitmap_allocator_top verification failed");
		$finish;
	end
endmodule
`default_nettype wire
